// ===== rtl/qtl_pkg.sv =====
package qtl_pkg;

  // One character of the line, or the end-of-line marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } sym_word_t;

  // One result word.
  typedef struct packed {
    logic       token_start;
    logic       char_valid;
    logic [7:0] out_char;
    logic [2:0] status;
    logic       line_done;
  } tok_word_t;

  typedef enum logic [6:0] {
    MODE_FIND    = 7'b0000001,
    MODE_READ    = 7'b0000010,
    MODE_COMMENT = 7'b0000100,
    MODE_DQUOTE  = 7'b0001000,
    MODE_SQUOTE  = 7'b0010000,
    MODE_ESCAPE  = 7'b0100000,
    MODE_ERROR   = 7'b1000000
  } mode_t;

  // Lexer state carried from one word to the next.
  typedef struct packed {
    mode_t mode;
    logic  esc_quoted;
  } lex_state_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OPEN_DQ = 3'd1;
  localparam logic [2:0] ST_OPEN_SQ = 3'd2;
  localparam logic [2:0] ST_END_BSL = 3'd3;
  localparam logic [2:0] ST_BAD_ESC = 3'd4;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

endpackage

// ===== rtl/qtl_step.sv =====
module qtl_step (
  input  qtl_pkg::lex_state_t lex,
  input  qtl_pkg::sym_word_t  sym,
  output qtl_pkg::lex_state_t lex_next,
  output qtl_pkg::tok_word_t  tok
);
  import qtl_pkg::*;

  logic       is_sep;
  logic       is_cmt;
  logic       start;
  logic       app;
  logic [7:0] och;
  logic [2:0] status;
  lex_state_t rd_next;
  logic       rd_app;

  assign is_sep = (sym.ch == CH_SPACE) || (sym.ch == CH_TAB);
  assign is_cmt = (sym.ch == CH_HASH) || (sym.ch == CH_BANG);

  // Handling of a character that starts or continues a bare token.
  always_comb begin
    rd_next = '{mode: MODE_READ, esc_quoted: lex.esc_quoted};
    rd_app  = 1'b0;
    if (is_sep) begin
      rd_next.mode = MODE_FIND;
    end else if (is_cmt) begin
      rd_next.mode = MODE_COMMENT;
    end else if (sym.ch == CH_DQUOTE) begin
      rd_next.mode = MODE_DQUOTE;
    end else if (sym.ch == CH_SQUOTE) begin
      rd_next.mode = MODE_SQUOTE;
    end else if (sym.ch == CH_BSLASH) begin
      rd_next.mode       = MODE_ESCAPE;
      rd_next.esc_quoted = 1'b0;
    end else begin
      rd_app = 1'b1;
    end
  end

  always_comb begin
    lex_next = lex;
    start    = 1'b0;
    app      = 1'b0;
    och      = sym.ch;
    status   = ST_OK;
    if (sym.line_end) begin
      case (lex.mode)
        MODE_DQUOTE: status = ST_OPEN_DQ;
        MODE_SQUOTE: status = ST_OPEN_SQ;
        MODE_ESCAPE: status = ST_END_BSL;
        default:     status = ST_OK;
      endcase
      lex_next = '{mode: MODE_FIND, esc_quoted: 1'b0};
    end else begin
      case (lex.mode)
        MODE_FIND: begin
          if (is_cmt) begin
            lex_next.mode = MODE_COMMENT;
          end else if (!is_sep) begin
            start    = 1'b1;
            lex_next = rd_next;
            app      = rd_app;
          end
        end
        MODE_READ: begin
          lex_next = rd_next;
          app      = rd_app;
        end
        MODE_DQUOTE: begin
          if (sym.ch == CH_DQUOTE) begin
            lex_next.mode = MODE_READ;
          end else if (sym.ch == CH_BSLASH) begin
            lex_next = '{mode: MODE_ESCAPE, esc_quoted: 1'b1};
          end else begin
            app = 1'b1;
          end
        end
        MODE_SQUOTE: begin
          if (sym.ch == CH_SQUOTE) begin
            lex_next.mode = MODE_READ;
          end else begin
            app = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          if (sym.ch == CH_SQUOTE || sym.ch == CH_DQUOTE || sym.ch == CH_BSLASH || is_sep) begin
            app           = 1'b1;
            lex_next.mode = lex.esc_quoted ? MODE_DQUOTE : MODE_READ;
          end else if (sym.ch == CH_LOWER_N) begin
            app           = 1'b1;
            och           = CH_NEWLINE;
            lex_next.mode = lex.esc_quoted ? MODE_DQUOTE : MODE_READ;
          end else begin
            status        = ST_BAD_ESC;
            lex_next.mode = MODE_ERROR;
          end
        end
        MODE_COMMENT: begin
        end
        // Error mode and any code outside the mode set drop characters.
        default: begin
        end
      endcase
    end
  end

  assign tok.token_start = start;
  assign tok.char_valid  = app;
  assign tok.out_char    = app ? och : 8'h00;
  assign tok.status      = status;
  assign tok.line_done   = sym.line_end;

endmodule

// ===== rtl/quoted_token_lexer.sv =====
// Shell-style line tokenizer. Each sym word carries one character of a line or an
// end-of-line marker; each produces exactly one tok word telling whether a token
// starts, which character (after escape translation) joins the current token, and
// an error status. Words pass through an input register, one step of lexer logic,
// and a result register, so one word is taken per clock cycle when the downstream
// side keeps tok_ready high. tok_valid rises when the held word moves from the
// input register into the result register. The rate is set by the update of
// the lexer mode register, which every word reads and writes. When tok is
// stalled, one further word can sit in the input register before sym_ready
// drops. After an error the rest of the line is ignored and the next
// end-of-line marker returns the lexer to its idle mode.
module quoted_token_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               sym_valid,
  output logic               sym_ready,
  input  qtl_pkg::sym_word_t sym,
  output logic               tok_valid,
  input  logic               tok_ready,
  output qtl_pkg::tok_word_t tok
);
  import qtl_pkg::*;

  // Input register.
  logic       held_valid;
  sym_word_t  held;

  // Lexer state and its next value from the step logic.
  lex_state_t lex;
  lex_state_t lex_next;
  tok_word_t  tok_next;

  // The held word moves into the result register when that register is empty
  // or its word is being taken in this cycle.
  logic       advance;

  assign advance   = held_valid && (!tok_valid || tok_ready);
  assign sym_ready = !held_valid || advance;

  qtl_step u_step (
    .lex      (lex),
    .sym      (held),
    .lex_next (lex_next),
    .tok      (tok_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sym_ready) begin
      held_valid <= sym_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_valid && sym_ready) begin
      held <= sym;
    end
  end

  // The lexer state changes only when a word is actually consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex <= '{mode: MODE_FIND, esc_quoted: 1'b0};
    end else if (advance) begin
      lex <= lex_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (advance) begin
      tok_valid <= 1'b1;
    end else if (tok_ready) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tok <= tok_next;
    end
  end

`ifndef ASSERT_OFF
  // An end-of-line marker always leaves the lexer idle with the escape origin cleared.
  a_eol_idle: assert property (@(posedge clk) disable iff (rst)
    advance && held.line_end |=> lex.mode == MODE_FIND && !lex.esc_quoted && tok.line_done)
    else $error("lexer not idle after end of line");

  // Characters seen in error mode produce an all-zero result word.
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && lex.mode == MODE_ERROR && !held.line_end |=> tok_valid && tok == '0)
    else $error("character in error mode produced output");

  // An escaped character is either appended or reported as an unknown escape.
  a_escape_result: assert property (@(posedge clk) disable iff (rst)
    advance && lex.mode == MODE_ESCAPE && !held.line_end
      |=> tok.char_valid || tok.status == ST_BAD_ESC)
    else $error("escape neither appended nor reported");

  // A word waiting in the input register with a free result register must move.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    held_valid && !tok_valid |=> tok_valid)
    else $error("held word not forwarded to free result register");
`endif

endmodule
